### hw/rtl/bsss_pkg.sv
// Shared constants for the byte set sort and statistics block.
// Used by the channel interfaces and the top level; depends on nothing.
package bsss_pkg;

  // Capacity of the sample store and the widths that follow from it.
  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // Fixed field widths of the words on the channels.
  localparam int DATA_W = 8;
  localparam int POS_W  = 6;

  // Running sum width, wide enough for a full store of 255s.
  localparam int SUM_W     = 14;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Reset values of the running extremes.
  localparam logic [DATA_W-1:0] MAX_RESET = '0;
  localparam logic [DATA_W-1:0] MIN_RESET = '1;

endpackage

### hw/rtl/bsss_in_if.sv
// Input channel of the sort block: one data byte per word and a last marker.
// Depends on bsss_pkg.
interface bsss_in_if import bsss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;
  logic              is_last;

  modport source (output valid, output sample, output is_last, input ready);
  modport sink   (input valid, input sample, input is_last, output ready);
endinterface

### hw/rtl/bsss_out_if.sv
// Result channel of the sort block: one sorted element with the set statistics.
// Depends on bsss_pkg.
interface bsss_out_if import bsss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sorted_value;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] maximum;
  logic [DATA_W-1:0] minimum;
  logic [DATA_W-1:0] mean;
  logic [DATA_W-1:0] median;
  logic              overflowed;
  logic              final_res;

  modport source (output valid, output sorted_value, output position, output maximum,
                  output minimum, output mean, output median, output overflowed,
                  output final_res, input ready);
  modport sink   (input valid, input sorted_value, input position, input maximum,
                  input minimum, input mean, input median, input overflowed,
                  input final_res, output ready);
endinterface

### hw/rtl/byte_set_sort_statistics.sv
// Byte set sort and statistics: loads a set of bytes into a RAM, sorts it and
// streams it back with max, min, mean and median. Depends on bsss_pkg,
// bsss_in_if, bsss_out_if and bsss_ram.
//
// Usage:
//   samples carries one unsigned byte per word; a word with is_last set closes
//   the set. Words are taken one per cycle while loading. Up to MAX_ITEMS bytes
//   are stored; later words of the same set are dropped and flag overflowed.
//   After the last word the block sorts the stored set in place with a
//   selection sort over the RAM: pass a reads entries a..n-1 through the single
//   read port and then writes the swap in S_SWAP_A and S_SWAP_B. A 14-step
//   shift-subtract divider forms the mean alongside the sort.
//   results then carries n words in ascending order; each word takes a RAM read
//   (S_EMIT_RD) and an output register load (S_EMIT_LD). The first result is
//   loaded only once both the sort and the divider are done; for sets of one
//   or two the divider is the one that finishes last.
//   samples.ready is low from the last word until the final result has been
//   loaded into the output register; the next set may load while that final
//   word still waits. A stalled receiver holds the output word and emission
//   waits on it; a new set may still load and sort behind a waiting final
//   word. Reset (rst, synchronous) clears the control state and the running
//   statistics; the RAM needs no clearing pass.
module byte_set_sort_statistics import bsss_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bsss_in_if.sink           samples,
  bsss_out_if.source        results
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state;

  // Running statistics of the current set.
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic [DATA_W-1:0] run_max;
  logic [DATA_W-1:0] run_min;
  logic              drop;

  // Sort pass state.
  logic [ADDR_W-1:0] pass_idx;
  logic [CNT_W-1:0]  rd_ptr;
  logic              pend;
  logic [ADDR_W-1:0] pend_idx;
  logic [DATA_W-1:0] best_val;
  logic [ADDR_W-1:0] best_idx;
  logic [DATA_W-1:0] a_val;
  logic [DATA_W-1:0] med_lo;
  logic [DATA_W-1:0] med_hi;
  logic [ADDR_W-1:0] emit_idx;

  // Mean divider.
  logic [SUM_W-1:0]     div_quo;
  logic [CNT_W-1:0]     div_rem;
  logic [CNT_W-1:0]     div_den;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Output register.
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic [POS_W-1:0]  out_pos;
  logic [DATA_W-1:0] out_max;
  logic [DATA_W-1:0] out_min;
  logic [DATA_W-1:0] out_mean;
  logic [DATA_W-1:0] out_median;
  logic              out_ovf;
  logic              out_final;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Load-side next values.
  logic              in_fire;
  logic              has_room;
  logic [CNT_W-1:0]  count_next;
  logic [SUM_W-1:0]  sum_next;
  logic [DATA_W-1:0] max_next;
  logic [DATA_W-1:0] min_next;

  // Derived values.
  logic [CNT_W-1:0]  last_idx;
  logic [ADDR_W-1:0] half_idx;
  logic [ADDR_W-1:0] half_m1;
  logic [DATA_W:0]   med_sum;
  logic [DATA_W-1:0] median_val;
  logic              slot_free;
  logic              out_load;
  logic              emit_last;
  logic [CNT_W:0]    div_trial;
  logic              div_take;

  bsss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshakes.
  assign samples.ready = (state == S_LOAD);
  assign in_fire       = samples.valid && samples.ready;
  assign slot_free     = !out_valid || results.ready;
  assign out_load      = (state == S_EMIT_LD) && slot_free && (div_cnt == '0);

  // Statistics update for an incoming word; a full store leaves them alone.
  always_comb begin
    has_room   = (count < CNT_W'(MAX_ITEMS));
    count_next = count;
    sum_next   = sum;
    max_next   = run_max;
    min_next   = run_min;
    if (has_room) begin
      count_next = count + CNT_W'(1);
      sum_next   = sum + SUM_W'(samples.sample);
      max_next   = (samples.sample > run_max) ? samples.sample : run_max;
      min_next   = (samples.sample < run_min) ? samples.sample : run_min;
    end
  end

  // Median from the two middle elements captured during the sort.
  assign last_idx   = count - CNT_W'(1);
  assign half_idx   = count[CNT_W-1:1];
  assign half_m1    = half_idx - ADDR_W'(1);
  assign med_sum    = {1'b0, med_lo} + {1'b0, med_hi};
  assign median_val = count[0] ? med_hi : med_sum[DATA_W:1];
  assign emit_last  = ({1'b0, emit_idx} == last_idx);

  // One restoring division step: shift in the next dividend bit and subtract.
  assign div_trial = {div_rem, div_quo[SUM_W-1]} - {1'b0, div_den};
  assign div_take  = !div_trial[CNT_W];

  // RAM port steering: loading and the two swap writes share the write port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[ADDR_W-1:0];
    ram_wdata = samples.sample;
    ram_raddr = emit_idx;
    unique case (state)
      S_LOAD: begin
        ram_we = in_fire && has_room;
      end
      S_SCAN: begin
        ram_raddr = rd_ptr[ADDR_W-1:0];
      end
      S_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx;
        ram_wdata = a_val;
      end
      S_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = pass_idx;
        ram_wdata = best_val;
      end
      S_EMIT_RD, S_EMIT_LD: begin
        ram_raddr = emit_idx;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Mean divider runs alongside the sort.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (in_fire && samples.is_last) begin
      div_quo <= sum_next;
      div_rem <= '0;
      div_den <= count_next;
      div_cnt <= DIV_CNT_W'(SUM_W);
    end else if (div_cnt != '0) begin
      div_rem <= div_take ? div_trial[CNT_W-1:0]
                          : {div_rem[CNT_W-2:0], div_quo[SUM_W-1]};
      div_quo <= {div_quo[SUM_W-2:0], div_take};
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // Control sequencer: load, selection sort passes, then emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      sum       <= '0;
      run_max   <= MAX_RESET;
      run_min   <= MIN_RESET;
      drop      <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The output word is valid from its load until it is taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            count   <= count_next;
            sum     <= sum_next;
            run_max <= max_next;
            run_min <= min_next;
            if (!has_room) begin
              drop <= 1'b1;
            end
            if (samples.is_last) begin
              pass_idx <= '0;
              rd_ptr   <= '0;
              pend     <= 1'b0;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue reads of the pass range and track the smallest entry.
          if (rd_ptr != count) begin
            rd_ptr <= rd_ptr + CNT_W'(1);
          end
          pend     <= (rd_ptr != count);
          pend_idx <= rd_ptr[ADDR_W-1:0];
          if (pend) begin
            if (pend_idx == pass_idx) begin
              a_val    <= ram_rdata;
              best_val <= ram_rdata;
              best_idx <= pass_idx;
            end else if (ram_rdata < best_val) begin
              best_val <= ram_rdata;
              best_idx <= pend_idx;
            end
          end
          if (rd_ptr == count) begin
            state <= S_SWAP_A;
          end
        end
        S_SWAP_A: begin
          // Entry pass_idx is now final; keep the middle ones for the median.
          if (pass_idx == half_m1) begin
            med_lo <= best_val;
          end
          if (pass_idx == half_idx) begin
            med_hi <= best_val;
          end
          state <= S_SWAP_B;
        end
        S_SWAP_B: begin
          pend <= 1'b0;
          if ({1'b0, pass_idx} == last_idx) begin
            emit_idx <= '0;
            state    <= S_EMIT_RD;
          end else begin
            pass_idx <= pass_idx + ADDR_W'(1);
            rd_ptr   <= {1'b0, pass_idx + ADDR_W'(1)};
            state    <= S_SCAN;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          // Read address is held, so the read word stays until the slot frees.
          if (out_load) begin
            out_value  <= ram_rdata;
            out_pos    <= POS_W'(emit_idx);
            out_max    <= run_max;
            out_min    <= run_min;
            out_mean   <= div_quo[DATA_W-1:0];
            out_median <= median_val;
            out_ovf    <= drop;
            out_final  <= emit_last;
            if (emit_last) begin
              count   <= '0;
              sum     <= '0;
              run_max <= MAX_RESET;
              run_min <= MIN_RESET;
              drop    <= 1'b0;
              state   <= S_LOAD;
            end else begin
              emit_idx <= emit_idx + ADDR_W'(1);
              state    <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Result channel.
  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.position     = out_pos;
  assign results.maximum      = out_max;
  assign results.minimum      = out_min;
  assign results.mean         = out_mean;
  assign results.median       = out_median;
  assign results.overflowed   = out_ovf;
  assign results.final_res    = out_final;

  // The fill count never passes the store capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("item count exceeds store capacity");

  // Words are only dropped once the store is full.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    drop |-> (count == CNT_W'(MAX_ITEMS)))
    else $error("drop flag set with room left in the store");

  // The value swapped into place is never larger than the one it replaces.
  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP_A) |-> (best_val <= a_val))
    else $error("selection pass picked a larger element");

  // While a non-final result is shown, no new set is being loaded.
  a_no_load_mid_run: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.final_res) |-> !samples.ready)
    else $error("input accepted while a run is still being emitted");

endmodule

### hw/rtl/bsss_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module bsss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in program order; a read in the following cycle sees new data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
